FILE: design/i2cwr_pkg.sv
// ----------------------------------------------------------------------------
// i2cwr_pkg
// Shared types and constants for the I2C write-then-read sequencer.
// ----------------------------------------------------------------------------
package i2cwr_pkg;

   localparam int ByteWidth    = 8;
   localparam int CtrlWidth    = 6;
   localparam int StatusWidth  = 2;

   // control word bits
   localparam logic [CtrlWidth-1:0] CB_EN   = 6'h01;
   localparam logic [CtrlWidth-1:0] CB_IE   = 6'h02;
   localparam logic [CtrlWidth-1:0] CB_MST  = 6'h04;
   localparam logic [CtrlWidth-1:0] CB_TX   = 6'h08;
   localparam logic [CtrlWidth-1:0] CB_TXAK = 6'h10;
   localparam logic [CtrlWidth-1:0] CB_RSTA = 6'h20;
   localparam logic [CtrlWidth-1:0] CB_NONE = 6'h00;

   localparam logic [ByteWidth-1:0] READ_BIT = 8'h01;

   typedef enum logic {
      CMD_START = 1'b0,
      CMD_EVENT = 1'b1
   } cmd_type;

   typedef enum logic [StatusWidth-1:0] {
      ST_OK       = 2'd0,
      ST_NAK      = 2'd1,
      ST_ARB_LOST = 2'd2
   } status_type;

   typedef enum logic [5:0] {
      PH_IDLE  = 6'b000001,
      PH_TX    = 6'b000010,
      PH_DUMMY = 6'b000100,
      PH_RX    = 6'b001000,
      PH_NAK   = 6'b010000,
      PH_ARBL  = 6'b100000
   } phase_type;

   typedef struct packed {
      phase_type            phase;
      logic [ByteWidth-1:0] tx_remaining;
      logic [ByteWidth-1:0] rx_remaining;
      logic [ByteWidth-1:0] stored_address;
   } seq_state_type;

   typedef struct packed {
      cmd_type              cmd;
      logic [ByteWidth-1:0] slave_address;
      logic [ByteWidth-1:0] tx_count;
      logic [ByteWidth-1:0] rx_count;
      logic                 nak_seen;
      logic                 arb_lost_seen;
      logic [ByteWidth-1:0] bus_rx_byte;
      logic [ByteWidth-1:0] next_tx_byte;
   } seq_item_type;

   typedef struct packed {
      logic                 control_write;
      logic [CtrlWidth-1:0] control_bits;
      logic                 data_write;
      logic [ByteWidth-1:0] data_byte;
      logic                 tx_taken;
      logic                 dummy_read;
      logic                 rx_valid;
      logic [ByteWidth-1:0] rx_byte;
      logic                 done_res;
      status_type           status_code;
   } seq_result_type;

endpackage

FILE: design/i2cwr_step.sv
// ----------------------------------------------------------------------------
// i2cwr_step
// Single-pass next-state and result logic for one sequencer word.
// ----------------------------------------------------------------------------
module i2cwr_step (
   input  i2cwr_pkg::seq_state_type  state_cur,
   input  i2cwr_pkg::seq_item_type   item,
   output i2cwr_pkg::seq_state_type  state_nxt,
   output i2cwr_pkg::seq_result_type result
);

   localparam logic [i2cwr_pkg::ByteWidth-1:0] One  = 8'd1;
   localparam logic [i2cwr_pkg::ByteWidth-1:0] Zero = 8'd0;

   logic                                 finish_check;
   logic [i2cwr_pkg::ByteWidth-1:0]      rx_dec;

   assign rx_dec = state_cur.rx_remaining - One;

   always_comb begin
      state_nxt    = state_cur;
      result       = '0;
      finish_check = 1'b0;

      if (item.cmd == i2cwr_pkg::CMD_START) begin
         state_nxt.stored_address = item.slave_address;
         state_nxt.tx_remaining   = item.tx_count;
         state_nxt.rx_remaining   = item.rx_count;
         state_nxt.phase          = i2cwr_pkg::PH_TX;
         result.control_write     = 1'b1;
         result.control_bits      = i2cwr_pkg::CB_EN | i2cwr_pkg::CB_IE |
                                    i2cwr_pkg::CB_MST | i2cwr_pkg::CB_TX;
         result.data_write        = 1'b1;
         result.data_byte         = item.slave_address;
      end else begin
         unique case (state_cur.phase)
            i2cwr_pkg::PH_TX: begin
               priority if (item.nak_seen) begin
                  state_nxt.phase = i2cwr_pkg::PH_NAK;
                  finish_check    = 1'b1;
               end else if (state_cur.tx_remaining != Zero) begin
                  result.data_write      = 1'b1;
                  result.data_byte       = item.next_tx_byte;
                  result.tx_taken        = 1'b1;
                  state_nxt.tx_remaining = state_cur.tx_remaining - One;
               end else if (state_cur.rx_remaining != Zero) begin
                  // repeated start with the read bit set
                  result.control_write = 1'b1;
                  result.control_bits  = i2cwr_pkg::CB_EN | i2cwr_pkg::CB_IE |
                                         i2cwr_pkg::CB_MST | i2cwr_pkg::CB_TX |
                                         i2cwr_pkg::CB_RSTA;
                  result.data_write    = 1'b1;
                  result.data_byte     = state_cur.stored_address | i2cwr_pkg::READ_BIT;
                  state_nxt.phase      = i2cwr_pkg::PH_DUMMY;
               end else begin
                  result.control_write = 1'b1;
                  result.control_bits  = i2cwr_pkg::CB_EN;
                  state_nxt.phase      = i2cwr_pkg::PH_IDLE;
                  finish_check         = 1'b1;
               end
            end
            i2cwr_pkg::PH_DUMMY: begin
               result.control_write = 1'b1;
               result.control_bits  = i2cwr_pkg::CB_EN | i2cwr_pkg::CB_IE |
                                      i2cwr_pkg::CB_MST |
                                      ((state_cur.rx_remaining == One) ?
                                       i2cwr_pkg::CB_TXAK : i2cwr_pkg::CB_NONE);
               result.dummy_read    = 1'b1;
               state_nxt.phase      = i2cwr_pkg::PH_RX;
            end
            i2cwr_pkg::PH_RX: begin
               if (state_cur.rx_remaining != Zero) begin
                  result.rx_valid        = 1'b1;
                  result.rx_byte         = item.bus_rx_byte;
                  state_nxt.rx_remaining = rx_dec;
                  if (rx_dec == One) begin
                     // turn acknowledge off before the last byte
                     result.control_write = 1'b1;
                     result.control_bits  = i2cwr_pkg::CB_EN | i2cwr_pkg::CB_IE |
                                            i2cwr_pkg::CB_MST | i2cwr_pkg::CB_TXAK;
                  end
                  if (rx_dec == Zero) begin
                     state_nxt.phase = i2cwr_pkg::PH_IDLE;
                     finish_check    = 1'b1;
                  end
               end else begin
                  finish_check = 1'b1;
               end
            end
            default: begin
               finish_check = 1'b1;
            end
         endcase

         if (finish_check) begin
            if (item.arb_lost_seen) begin
               state_nxt.phase = i2cwr_pkg::PH_ARBL;
            end
            if (state_nxt.phase == i2cwr_pkg::PH_IDLE ||
                state_nxt.phase == i2cwr_pkg::PH_NAK ||
                state_nxt.phase == i2cwr_pkg::PH_ARBL) begin
               result.control_write = 1'b1;
               result.control_bits  = i2cwr_pkg::CB_NONE;
               result.done_res      = 1'b1;
               priority if (state_nxt.phase == i2cwr_pkg::PH_NAK) begin
                  result.status_code = i2cwr_pkg::ST_NAK;
               end else if (state_nxt.phase == i2cwr_pkg::PH_ARBL) begin
                  result.status_code = i2cwr_pkg::ST_ARB_LOST;
               end else begin
                  result.status_code = i2cwr_pkg::ST_OK;
               end
            end
         end
      end
   end

endmodule

FILE: design/i2c_write_read_sequencer_unit.sv
// ----------------------------------------------------------------------------
// i2c_write_read_sequencer_unit
// I2C master write-then-read sequencer with a repeated start.
// ----------------------------------------------------------------------------
// Each request word (a start, or one byte-complete event from the bus
// controller) yields exactly one response word, registered when the word is
// accepted. The sequencer state and the response register update in the same
// cycle, so a new request word is taken every clock: req_ready is high
// whenever the response register is empty or its word is taken in that same
// cycle, and low only while a response word waits on rsp_ready (and during
// reset). A start replaces any transfer in progress. The response tells the
// driver what to do with the controller: write the control word, write a data
// byte (address, address with read bit, or payload), consume the offered
// payload byte, perform the dummy read, or hand over a received byte. A
// response with done_res set carries the final status and a control word of
// zero, which disables the controller.
// ----------------------------------------------------------------------------
module i2c_write_read_sequencer_unit (
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_cmd,
   input  logic [7:0] req_slave_address,
   input  logic [7:0] req_tx_count,
   input  logic [7:0] req_rx_count,
   input  logic       req_nak_seen,
   input  logic       req_arb_lost_seen,
   input  logic [7:0] req_bus_rx_byte,
   input  logic [7:0] req_next_tx_byte,

   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_control_write,
   output logic [5:0] rsp_control_bits,
   output logic       rsp_data_write,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_tx_taken,
   output logic       rsp_dummy_read,
   output logic       rsp_rx_valid,
   output logic [7:0] rsp_rx_byte,
   output logic       rsp_done_res,
   output logic [1:0] rsp_status_code
);

   i2cwr_pkg::seq_state_type  state_ff, state_in;
   i2cwr_pkg::seq_item_type   item;
   i2cwr_pkg::seq_result_type result_ff, result_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      req_fire;

   // gather the request word
   assign item.cmd           = i2cwr_pkg::cmd_type'(req_cmd);
   assign item.slave_address = req_slave_address;
   assign item.tx_count      = req_tx_count;
   assign item.rx_count      = req_rx_count;
   assign item.nak_seen      = req_nak_seen;
   assign item.arb_lost_seen = req_arb_lost_seen;
   assign item.bus_rx_byte   = req_bus_rx_byte;
   assign item.next_tx_byte  = req_next_tx_byte;

   // accept when the response register is free or drains this cycle
   assign req_ready = ~reset & (~rsp_valid_ff | rsp_ready);
   assign req_fire  = req_valid & req_ready;

   i2cwr_step u_step (
      .state_cur (state_ff),
      .item      (item),
      .state_nxt (state_in),
      .result    (result_in)
   );

   // hold the response until taken, drop the valid flag once it leaves
   always_comb begin
      priority if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase          <= i2cwr_pkg::PH_IDLE;
         state_ff.tx_remaining   <= '0;
         state_ff.rx_remaining   <= '0;
         state_ff.stored_address <= '0;
         rsp_valid_ff            <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            state_ff <= state_in;
         end
      end
   end

   // response payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_control_write = result_ff.control_write;
   assign rsp_control_bits  = result_ff.control_bits;
   assign rsp_data_write    = result_ff.data_write;
   assign rsp_data_byte     = result_ff.data_byte;
   assign rsp_tx_taken      = result_ff.tx_taken;
   assign rsp_dummy_read    = result_ff.dummy_read;
   assign rsp_rx_valid      = result_ff.rx_valid;
   assign rsp_rx_byte       = result_ff.rx_byte;
   assign rsp_done_res      = result_ff.done_res;
   assign rsp_status_code   = result_ff.status_code;

   // a finished transfer always disables the controller
   a_done_disables: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && result_ff.done_res |->
         result_ff.control_write && (result_ff.control_bits == i2cwr_pkg::CB_NONE))
      else $error("done response without a zero control word");

   // a start always moves the sequencer to transmit
   a_start_to_tx: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_cmd == i2cwr_pkg::CMD_START) |=>
         state_ff.phase == i2cwr_pkg::PH_TX)
      else $error("start did not enter transmit phase");

   // received bytes come only out of the receive phase
   a_rx_from_rx: assert property (@(posedge clock) disable iff (reset)
      $past(req_fire) && result_ff.rx_valid |->
         $past(state_ff.phase) == i2cwr_pkg::PH_RX)
      else $error("received byte outside receive phase");

   // each consumed payload byte counts down the transmit budget
   a_tx_count: assert property (@(posedge clock) disable iff (reset)
      $past(req_fire) && result_ff.tx_taken |->
         state_ff.tx_remaining == $past(state_ff.tx_remaining) - 8'd1)
      else $error("payload byte taken without count down");

endmodule

FILE: tb/i2c_write_read_sequencer_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_write_read_sequencer_unit_tb
// Self-checking bench for the I2C write-then-read sequencer.
// ----------------------------------------------------------------------------
// Request words (starts and byte-complete events) go in through a valid/ready
// handshake. A predictor in the bench tracks the transfer phase, the byte
// counts left and the target address, and queues the controller actions that
// each accepted word should cause. Every response word is checked field by
// field against the oldest queued action. A short directed part walks the
// write, repeated-start, dummy-read and read paths, the NAK and
// arbitration-loss endings and a start that cuts into a running transfer.
// Random transfers with noise, idle gaps on both sides, a run with no gaps and
// a long receiver hold-off follow.
// ----------------------------------------------------------------------------
module i2c_write_read_sequencer_unit_tb;

   localparam int ClockHalf   = 2;
   localparam int ResetCycles = 6;
   localparam int CycleLimit  = 200000;
   localparam int DrainCycles = 8;
   localparam int HoldCycles  = 150;

   logic       clock = 1'b0;
   logic       reset = 1'b1;

   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_cmd = 1'b0;
   logic [7:0] req_slave_address = 8'h00;
   logic [7:0] req_tx_count = 8'h00;
   logic [7:0] req_rx_count = 8'h00;
   logic       req_nak_seen = 1'b0;
   logic       req_arb_lost_seen = 1'b0;
   logic [7:0] req_bus_rx_byte = 8'h00;
   logic [7:0] req_next_tx_byte = 8'h00;

   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_control_write;
   logic [5:0] rsp_control_bits;
   logic       rsp_data_write;
   logic [7:0] rsp_data_byte;
   logic       rsp_tx_taken;
   logic       rsp_dummy_read;
   logic       rsp_rx_valid;
   logic [7:0] rsp_rx_byte;
   logic       rsp_done_res;
   logic [1:0] rsp_status_code;

   // predictor state
   i2cwr_pkg::phase_type      seq_phase      = i2cwr_pkg::PH_IDLE;
   logic [7:0]                bytes_to_send  = 8'h00;
   logic [7:0]                bytes_to_read  = 8'h00;
   logic [7:0]                target_address = 8'h00;
   i2cwr_pkg::seq_result_type expected_actions[$];

   // run control and tallies
   int   src_idle_pct  = 38;
   int   sink_idle_pct = 38;
   logic sink_hold     = 1'b0;
   int   cycle_count   = 0;
   int   error_count   = 0;
   int   words_sent    = 0;
   int   starts_sent   = 0;
   int   events_sent   = 0;
   int   rx_bytes_seen = 0;
   int   ok_done       = 0;
   int   nak_done      = 0;
   int   arb_done      = 0;

   i2c_write_read_sequencer_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_slave_address (req_slave_address),
      .req_tx_count      (req_tx_count),
      .req_rx_count      (req_rx_count),
      .req_nak_seen      (req_nak_seen),
      .req_arb_lost_seen (req_arb_lost_seen),
      .req_bus_rx_byte   (req_bus_rx_byte),
      .req_next_tx_byte  (req_next_tx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_control_write (rsp_control_write),
      .rsp_control_bits  (rsp_control_bits),
      .rsp_data_write    (rsp_data_write),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_tx_taken      (rsp_tx_taken),
      .rsp_dummy_read    (rsp_dummy_read),
      .rsp_rx_valid      (rsp_rx_valid),
      .rsp_rx_byte       (rsp_rx_byte),
      .rsp_done_res      (rsp_done_res),
      .rsp_status_code   (rsp_status_code)
   );

   always #ClockHalf clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("Timeout after %0d cycles, %0d words still expected",
                  cycle_count, expected_actions.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Work out the controller actions for one accepted word and advance the
   // transfer state.
   function automatic i2cwr_pkg::seq_result_type compute_bus_actions(
      input i2cwr_pkg::seq_item_type w);
      i2cwr_pkg::seq_result_type r;
      r = '0;
      if (w.cmd == i2cwr_pkg::CMD_START) begin
         // a start always wins, even over a transfer in progress
         target_address = w.slave_address;
         bytes_to_send  = w.tx_count;
         bytes_to_read  = w.rx_count;
         r.control_write = 1'b1;
         r.control_bits  = i2cwr_pkg::CB_EN | i2cwr_pkg::CB_IE |
                           i2cwr_pkg::CB_MST | i2cwr_pkg::CB_TX;
         r.data_write    = 1'b1;
         r.data_byte     = w.slave_address;
         seq_phase       = i2cwr_pkg::PH_TX;
         return r;
      end
      case (seq_phase)
         i2cwr_pkg::PH_TX: begin
            if (w.nak_seen) begin
               seq_phase = i2cwr_pkg::PH_NAK;
            end else if (bytes_to_send != 8'd0) begin
               r.data_write  = 1'b1;
               r.data_byte   = w.next_tx_byte;
               r.tx_taken    = 1'b1;
               bytes_to_send = bytes_to_send - 8'd1;
               return r;
            end else if (bytes_to_read != 8'd0) begin
               // repeated start with the read bit set
               r.control_write = 1'b1;
               r.control_bits  = i2cwr_pkg::CB_EN | i2cwr_pkg::CB_IE |
                                 i2cwr_pkg::CB_MST | i2cwr_pkg::CB_TX |
                                 i2cwr_pkg::CB_RSTA;
               r.data_write    = 1'b1;
               r.data_byte     = target_address | i2cwr_pkg::READ_BIT;
               seq_phase       = i2cwr_pkg::PH_DUMMY;
               return r;
            end else begin
               r.control_write = 1'b1;
               r.control_bits  = i2cwr_pkg::CB_EN;
               seq_phase       = i2cwr_pkg::PH_IDLE;
            end
         end
         i2cwr_pkg::PH_DUMMY: begin
            r.control_write = 1'b1;
            r.control_bits  = i2cwr_pkg::CB_EN | i2cwr_pkg::CB_IE | i2cwr_pkg::CB_MST;
            if (bytes_to_read == 8'd1)
               r.control_bits = r.control_bits | i2cwr_pkg::CB_TXAK;
            r.dummy_read = 1'b1;
            seq_phase    = i2cwr_pkg::PH_RX;
            return r;
         end
         i2cwr_pkg::PH_RX: begin
            if (bytes_to_read != 8'd0) begin
               r.rx_valid    = 1'b1;
               r.rx_byte     = w.bus_rx_byte;
               bytes_to_read = bytes_to_read - 8'd1;
               // turn acknowledge off ahead of the last byte
               if (bytes_to_read == 8'd1) begin
                  r.control_write = 1'b1;
                  r.control_bits  = i2cwr_pkg::CB_EN | i2cwr_pkg::CB_IE |
                                    i2cwr_pkg::CB_MST | i2cwr_pkg::CB_TXAK;
               end
               if (bytes_to_read != 8'd0) return r;
               seq_phase = i2cwr_pkg::PH_IDLE;
            end
         end
         default: ;
      endcase
      // only the paths that fall through to here see arbitration loss
      if (w.arb_lost_seen) seq_phase = i2cwr_pkg::PH_ARBL;
      if (seq_phase == i2cwr_pkg::PH_IDLE || seq_phase == i2cwr_pkg::PH_NAK ||
          seq_phase == i2cwr_pkg::PH_ARBL) begin
         r.control_write = 1'b1;
         r.control_bits  = i2cwr_pkg::CB_NONE;
         r.done_res      = 1'b1;
         r.status_code   = (seq_phase == i2cwr_pkg::PH_NAK)  ? i2cwr_pkg::ST_NAK :
                           (seq_phase == i2cwr_pkg::PH_ARBL) ? i2cwr_pkg::ST_ARB_LOST :
                                                               i2cwr_pkg::ST_OK;
      end
      return r;
   endfunction

   function automatic i2cwr_pkg::seq_item_type random_word();
      i2cwr_pkg::seq_item_type w;
      w.cmd           = $urandom_range(1) ? i2cwr_pkg::CMD_EVENT : i2cwr_pkg::CMD_START;
      w.slave_address = 8'($urandom_range(255));
      w.tx_count      = 8'($urandom_range(255));
      w.rx_count      = 8'($urandom_range(255));
      w.nak_seen      = 1'($urandom_range(1));
      w.arb_lost_seen = 1'($urandom_range(1));
      w.bus_rx_byte   = 8'($urandom_range(255));
      w.next_tx_byte  = 8'($urandom_range(255));
      return w;
   endfunction

   // unused fields stay random so the block is seen to ignore them
   function automatic i2cwr_pkg::seq_item_type start_word(input logic [7:0] addr, txc, rxc);
      i2cwr_pkg::seq_item_type w;
      w = random_word();
      w.cmd           = i2cwr_pkg::CMD_START;
      w.slave_address = addr;
      w.tx_count      = txc;
      w.rx_count      = rxc;
      return w;
   endfunction

   function automatic i2cwr_pkg::seq_item_type byte_done_word(input logic nak, arb);
      i2cwr_pkg::seq_item_type w;
      w = random_word();
      w.cmd           = i2cwr_pkg::CMD_EVENT;
      w.nak_seen      = nak;
      w.arb_lost_seen = arb;
      return w;
   endfunction

   // Offer one word, hold it until accepted, then queue what it should cause.
   task automatic send_word(input i2cwr_pkg::seq_item_type w);
      i2cwr_pkg::seq_result_type r;
      if ($urandom_range(99) < src_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < src_idle_pct) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_cmd           <= w.cmd;
      req_slave_address <= w.slave_address;
      req_tx_count      <= w.tx_count;
      req_rx_count      <= w.rx_count;
      req_nak_seen      <= w.nak_seen;
      req_arb_lost_seen <= w.arb_lost_seen;
      req_bus_rx_byte   <= w.bus_rx_byte;
      req_next_tx_byte  <= w.next_tx_byte;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      r = compute_bus_actions(w);
      expected_actions.push_back(r);
      words_sent++;
      if (w.cmd == i2cwr_pkg::CMD_START) starts_sent++;
      else events_sent++;
      if (r.rx_valid) rx_bytes_seen++;
      if (r.done_res) begin
         if (r.status_code == i2cwr_pkg::ST_NAK) nak_done++;
         else if (r.status_code == i2cwr_pkg::ST_ARB_LOST) arb_done++;
         else ok_done++;
      end
   endtask

   function automatic void check_field(input string name, input logic [7:0] want, got);
      if (want !== got) begin
         error_count++;
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      end
   endfunction

   // Response side: check each accepted word, then pick next cycle's ready.
   always @(posedge clock) begin
      i2cwr_pkg::seq_result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_actions.size() == 0) begin
            error_count++;
            $error("response word arrived with nothing expected");
         end else begin
            e = expected_actions.pop_front();
            check_field("control_write", 8'(e.control_write), 8'(rsp_control_write));
            check_field("control_bits",  8'(e.control_bits),  8'(rsp_control_bits));
            check_field("data_write",    8'(e.data_write),    8'(rsp_data_write));
            check_field("data_byte",     e.data_byte,         rsp_data_byte);
            check_field("tx_taken",      8'(e.tx_taken),      8'(rsp_tx_taken));
            check_field("dummy_read",    8'(e.dummy_read),    8'(rsp_dummy_read));
            check_field("rx_valid",      8'(e.rx_valid),      8'(rsp_rx_valid));
            check_field("rx_byte",       e.rx_byte,           rsp_rx_byte);
            check_field("done_res",      8'(e.done_res),      8'(rsp_done_res));
            check_field("status_code",   8'(e.status_code),   8'(rsp_status_code));
         end
      end
      rsp_ready <= !sink_hold && ($urandom_range(99) >= sink_idle_pct);
   end

   // Write-only transfer, then events in the idle and arbitration-lost ends.
   task automatic test_write_only();
      send_word(start_word(8'h00, 8'd0, 8'd0));
      send_word(byte_done_word(1'b0, 1'b0));
      send_word(byte_done_word(1'b0, 1'b1));
      send_word(byte_done_word(1'b0, 1'b0));
   endtask

   // Two bytes out, repeated start, dummy read, two bytes in. Arbitration loss
   // on early-return paths must be ignored.
   task automatic test_write_then_read();
      send_word(start_word(8'hA4, 8'd2, 8'd2));
      send_word(byte_done_word(1'b0, 1'b1));
      send_word(byte_done_word(1'b0, 1'b0));
      send_word(byte_done_word(1'b0, 1'b1));
      send_word(byte_done_word(1'b0, 1'b1));
      send_word(byte_done_word(1'b0, 1'b0));
      send_word(byte_done_word(1'b0, 1'b0));
   endtask

   // One byte each way: no-ack set at the dummy read, arbitration lost on the
   // last received byte.
   task automatic test_single_read();
      send_word(start_word(8'hFF, 8'd1, 8'd1));
      send_word(byte_done_word(1'b0, 1'b0));
      send_word(byte_done_word(1'b0, 1'b0));
      send_word(byte_done_word(1'b0, 1'b0));
      send_word(byte_done_word(1'b0, 1'b1));
   endtask

   // NAK while bytes remain, then events in the NAK end.
   task automatic test_nak_end();
      send_word(start_word(8'h5A, 8'd3, 8'd0));
      send_word(byte_done_word(1'b1, 1'b0));
      send_word(byte_done_word(1'b0, 1'b0));
      send_word(byte_done_word(1'b1, 1'b1));
   endtask

   // A start replaces a transfer at the largest counts.
   task automatic test_restart_while_busy();
      send_word(start_word(8'h3C, 8'd255, 8'd255));
      send_word(byte_done_word(1'b0, 1'b0));
      send_word(start_word(8'h11, 8'd0, 8'd1));
      send_word(byte_done_word(1'b0, 1'b0));
      send_word(byte_done_word(1'b0, 1'b0));
      send_word(byte_done_word(1'b0, 1'b0));
   endtask

   // Mostly well-formed transfers with random data, some aborted by a new
   // start, some followed by stray events, and bursts of pure noise.
   task automatic test_random_transfers(input int count);
      int         stop_at;
      logic [7:0] txc;
      logic [7:0] rxc;
      stop_at = words_sent + count;
      while (words_sent < stop_at) begin
         if ($urandom_range(99) < 12) begin
            repeat ($urandom_range(3, 1)) send_word(random_word());
         end else begin
            // keep transfers short, with a rare one at full length
            if ($urandom_range(199) == 0) begin
               txc = 8'($urandom_range(255));
               rxc = 8'($urandom_range(255));
            end else begin
               txc = 8'($urandom_range(4));
               rxc = 8'($urandom_range(4));
            end
            send_word(start_word(8'($urandom_range(255)), txc, rxc));
            while ((seq_phase == i2cwr_pkg::PH_TX || seq_phase == i2cwr_pkg::PH_DUMMY ||
                    seq_phase == i2cwr_pkg::PH_RX) && words_sent < stop_at) begin
               if ($urandom_range(99) < 3) break;
               send_word(byte_done_word($urandom_range(99) < 6, $urandom_range(99) < 4));
            end
            if ($urandom_range(99) < 10)
               send_word(byte_done_word(1'($urandom_range(1)), 1'($urandom_range(1))));
         end
      end
   endtask

   // Both sides run without gaps.
   task automatic test_back_to_back(input int count);
      src_idle_pct = 0;
      sink_idle_pct <= 0;
      test_random_transfers(count);
      src_idle_pct = 38;
      sink_idle_pct <= 38;
   endtask

   // Receiver holds off for a long stretch while words keep coming, so the
   // response register fills and req_ready drops.
   task automatic test_receiver_hold(input int count);
      fork
         begin
            sink_hold <= 1'b1;
            repeat (HoldCycles) @(posedge clock);
            sink_hold <= 1'b0;
         end
      join_none
      src_idle_pct = 0;
      test_random_transfers(count);
      src_idle_pct = 38;
   endtask

   initial begin
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      test_write_only();
      test_write_then_read();
      test_single_read();
      test_nak_end();
      test_restart_while_busy();
      test_random_transfers(800);
      test_back_to_back(250);
      test_receiver_hold(40);
      test_random_transfers(760);
      req_valid <= 1'b0;
      while (expected_actions.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (expected_actions.size() != 0) begin
         error_count++;
         $error("%0d response words never arrived", expected_actions.size());
      end
      $display("Sent %0d words: %0d starts, %0d byte-complete events, %0d bytes read back",
               words_sent, starts_sent, events_sent, rx_bytes_seen);
      $display("Transfer endings: %0d ok, %0d nak, %0d arbitration lost",
               ok_done, nak_done, arb_done);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
